// ----- src/ssev_pkg.sv -----
// Shared types, constants and command codes for the sprite scanline evaluator.
package ssev_pkg;

  localparam int STORE_SPRITES_DEF = 64;
  localparam int MAX_PER_LINE_DEF  = 8;
  localparam int SPRITE_HEIGHT_DEF = 8;

  localparam logic [7:0] UNUSED_BYTE = 8'hFF;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] oam_byte;
    logic [7:0] scanline;
  } ssev_in_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       found;
    logic [7:0] sprite_y;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attr;
    logic [7:0] sprite_x;
    logic [3:0] sprite_count;
    logic       last;
  } ssev_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_EMIT
  } ssev_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SCAN,
    OP_F1,
    OP_F2,
    OP_F3,
    OP_EMIT
  } ssev_op_t;

  typedef struct packed {
    ssev_op_t op;
  } ssev_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic emit_last;
  } ssev_stat_t;

endpackage

// ----- src/ssev_ctrl.sv -----
// Controller state machine that sequences loads, the entry scan and slot output.
module ssev_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              mode,
  input  ssev_pkg::ssev_stat_t stat,
  output ssev_pkg::ssev_cmd_t  cmd,
  output logic              busy
);

  ssev_pkg::ssev_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssev_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ssev_pkg::OP_NONE;
    busy      = (state_r != ssev_pkg::ST_IDLE);
    case (state_r)
      ssev_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == ssev_pkg::MODE_LOAD) begin
            cmd.op = ssev_pkg::OP_LOAD;
          end else begin
            cmd.op    = ssev_pkg::OP_INIT;
            state_nxt = ssev_pkg::ST_SCAN;
          end
        end
      end
      ssev_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ssev_pkg::ST_EMIT;
        end else begin
          cmd.op = ssev_pkg::OP_SCAN;
          if (stat.hit) begin
            state_nxt = ssev_pkg::ST_F1;
          end
        end
      end
      ssev_pkg::ST_F1: begin
        cmd.op    = ssev_pkg::OP_F1;
        state_nxt = ssev_pkg::ST_F2;
      end
      ssev_pkg::ST_F2: begin
        cmd.op    = ssev_pkg::OP_F2;
        state_nxt = ssev_pkg::ST_F3;
      end
      ssev_pkg::ST_F3: begin
        cmd.op    = ssev_pkg::OP_F3;
        state_nxt = ssev_pkg::ST_SCAN;
      end
      ssev_pkg::ST_EMIT: begin
        cmd.op = ssev_pkg::OP_EMIT;
        if (stat.emit_last) begin
          state_nxt = ssev_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssev_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ssev_dp.sv -----
// Datapath with the attribute store, scan counters, selected slots and result register.
module ssev_dp #(
  parameter int STORE_SPRITES = ssev_pkg::STORE_SPRITES_DEF,
  parameter int MAX_PER_LINE  = ssev_pkg::MAX_PER_LINE_DEF,
  parameter int SPRITE_HEIGHT = ssev_pkg::SPRITE_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssev_pkg::ssev_in_t   in_word,
  input  ssev_pkg::ssev_cmd_t  cmd,
  output ssev_pkg::ssev_stat_t stat,
  output logic                 out_valid,
  output ssev_pkg::ssev_out_t  out_word
);

  localparam int EW   = $clog2(STORE_SPRITES + 1);
  localparam int CNTW = $clog2(MAX_PER_LINE + 1);
  localparam int SW   = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

  logic [7:0] store_r [256];
  logic [7:0] rdata_r;
  logic [7:0] rd_addr;
  logic [7:0] wp_r, wp_nxt;

  logic [7:0]      line_r, line_nxt;
  logic [EW-1:0]   issue_r, issue_nxt;
  logic [EW-1:0]   pend_entry_r, pend_entry_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;

  logic [7:0] sel_r [MAX_PER_LINE][4];
  logic       sel_we;
  logic [1:0] sel_byte;

  logic                out_valid_r, out_valid_nxt;
  ssev_pkg::ssev_out_t out_res_r, out_res_nxt;

  logic [7:0] pend_base;
  logic [7:0] issue_base;
  logic [7:0] diff;
  logic       y_ok;
  logic       hit;
  logic       found;
  logic [SW-1:0] wr_idx;

  assign pend_base  = 8'({pend_entry_r, 2'b00});
  assign issue_base = 8'({issue_r, 2'b00});
  assign diff       = line_r - rdata_r;
  assign y_ok       = (rdata_r <= line_r) && ({1'b0, diff} < 9'(SPRITE_HEIGHT));
  assign hit        = pend_valid_r && y_ok;
  assign wr_idx     = SW'(count_r);
  assign found      = (CNTW'(slot_r) < count_r);

  assign stat.hit       = hit;
  assign stat.scan_done = (count_r == CNTW'(MAX_PER_LINE)) ||
                          (!pend_valid_r && (issue_r == EW'(STORE_SPRITES)));
  assign stat.emit_last = (slot_r == SW'(MAX_PER_LINE - 1));

  always_ff @(posedge clk) begin
    if ((cmd.op == ssev_pkg::OP_LOAD)) begin
      store_r[wp_r] <= in_word.oam_byte;
    end
    rdata_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sel_we) begin
      sel_r[wr_idx][sel_byte] <= rdata_r;
    end
  end

  always_comb begin
    wp_nxt         = wp_r;
    line_nxt       = line_r;
    issue_nxt      = issue_r;
    pend_entry_nxt = pend_entry_r;
    pend_valid_nxt = pend_valid_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    rd_addr        = issue_base;
    sel_we         = 1'b0;
    sel_byte       = 2'd0;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    case (cmd.op)
      ssev_pkg::OP_LOAD: begin
        wp_nxt = wp_r + 8'd1;
      end
      ssev_pkg::OP_INIT: begin
        line_nxt       = in_word.scanline;
        issue_nxt      = '0;
        pend_valid_nxt = 1'b0;
        count_nxt      = '0;
        slot_nxt       = '0;
      end
      ssev_pkg::OP_SCAN: begin
        if (hit) begin
          sel_we         = 1'b1;
          sel_byte       = 2'd0;
          rd_addr        = pend_base | 8'd1;
          pend_valid_nxt = 1'b0;
          issue_nxt      = pend_entry_r + EW'(1);
        end else if (issue_r < EW'(STORE_SPRITES)) begin
          rd_addr        = issue_base;
          pend_valid_nxt = 1'b1;
          pend_entry_nxt = issue_r;
          issue_nxt      = issue_r + EW'(1);
        end else begin
          pend_valid_nxt = 1'b0;
        end
      end
      ssev_pkg::OP_F1: begin
        sel_we   = 1'b1;
        sel_byte = 2'd1;
        rd_addr  = pend_base | 8'd2;
      end
      ssev_pkg::OP_F2: begin
        sel_we   = 1'b1;
        sel_byte = 2'd2;
        rd_addr  = pend_base | 8'd3;
      end
      ssev_pkg::OP_F3: begin
        sel_we    = 1'b1;
        sel_byte  = 2'd3;
        count_nxt = count_r + CNTW'(1);
      end
      ssev_pkg::OP_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_res_nxt.slot         = 3'(slot_r);
        out_res_nxt.found        = found;
        out_res_nxt.sprite_y     = found ? sel_r[slot_r][0] : ssev_pkg::UNUSED_BYTE;
        out_res_nxt.sprite_tile  = found ? sel_r[slot_r][1] : ssev_pkg::UNUSED_BYTE;
        out_res_nxt.sprite_attr  = found ? sel_r[slot_r][2] : ssev_pkg::UNUSED_BYTE;
        out_res_nxt.sprite_x     = found ? sel_r[slot_r][3] : ssev_pkg::UNUSED_BYTE;
        out_res_nxt.sprite_count = (32'(count_r) > 32'd15) ? 4'd15 : 4'(count_r);
        out_res_nxt.last         = stat.emit_last;
        slot_nxt                 = slot_r + SW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      slot_r       <= '0;
      issue_r      <= '0;
    end else begin
      wp_r         <= wp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      slot_r       <= slot_nxt;
      issue_r      <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r       <= line_nxt;
    pend_entry_r <= pend_entry_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_PER_LINE))
    else $error("selected sprite count exceeds slot capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ssev_pkg::OP_F3) |=> (count_r == CNTW'($past(count_r) + CNTW'(1))))
    else $error("sprite count did not advance after the last byte fetch");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.found) |-> (out_res_r.sprite_count != 4'd0))
    else $error("found slot reported with zero sprite count");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_entry_r < EW'(STORE_SPRITES)))
    else $error("pending entry index out of range");

endmodule

// ----- src/sprite_scanline_evaluator_top.sv -----
// Load word: written at the accepting edge; busy stays low, so loads can follow every cycle.
// Evaluate word: busy through the entry scan and the slot output, with the scan held while a
// selected sprite's remaining bytes are fetched in states F1, F2 and F3.
// Scan reads one entry per cycle save during byte fetches; slot words follow one per cycle,
// the last one registered as busy falls; each is valid for one cycle (receiver cannot stall).
// Reset clears the write pointer and control state; the store is undefined until loaded.
module sprite_scanline_evaluator_top #(
  parameter int STORE_SPRITES = ssev_pkg::STORE_SPRITES_DEF,
  parameter int MAX_PER_LINE  = ssev_pkg::MAX_PER_LINE_DEF,
  parameter int SPRITE_HEIGHT = ssev_pkg::SPRITE_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssev_pkg::ssev_in_t  in_word,
  output logic                out_valid,
  output ssev_pkg::ssev_out_t out_word
);

  ssev_pkg::ssev_cmd_t  cmd;
  ssev_pkg::ssev_stat_t stat;

  ssev_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_word.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ssev_dp #(
    .STORE_SPRITES (STORE_SPRITES),
    .MAX_PER_LINE  (MAX_PER_LINE),
    .SPRITE_HEIGHT (SPRITE_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
